[rtl/core/rotation_matrix_to_euler_angles_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_ASSERT_SVH

// Check that a condition leads to a consequence at the next edge.
`define RME_ASSERT_NEXT(label, clk_sig, rst_sig, cond, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (cons)) \
    else $error(msg);

// Check that a condition holds at every edge.
`define RME_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error(msg);

`endif

[rtl/core/rme_pkg.sv]
`default_nettype none
package rme_pkg;

  localparam int ElemW  = 16;
  localparam int AngW   = 16;
  localparam int ThrW   = 15;
  localparam int DataW  = 40;
  localparam int ZW     = 34;
  localparam int TabLen = 24;
  localparam int NumVec = 4;

  localparam logic signed [ZW-1:0] HalfPi   = 34'sd1686629713;
  localparam logic signed [31:0]   InvGain  = 32'sd652032874;
  localparam logic signed [AngW-1:0] AngLimit = 16'sd25736;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [ZW-1:0]    ang_t;

  typedef struct packed {
    data_t x;
    data_t y;
    ang_t  z;
    logic  zero;
  } vec_t;

  function automatic ang_t atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return ang_t'({2'b00, v});
  endfunction

  // Pre-rotate into the right half plane and seed the angle.
  function automatic vec_t vec_init(input data_t x, input data_t y);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0 && y >= 0) begin
      v.x = y; v.y = -x; v.z = HalfPi;
    end else if (x < 0) begin
      v.x = -y; v.y = x; v.z = -HalfPi;
    end else begin
      v.x = x; v.y = y; v.z = '0;
    end
    return v;
  endfunction

  function automatic logic signed [AngW-1:0] angle_out(input vec_t v);
    logic signed [ZW:0] r;
    logic signed [ZW:0] s;
    r = (ZW+1)'(v.z) + (ZW+1)'(65536);
    s = r >>> 17;
    if (v.zero) return '0;
    if (s > (ZW+1)'(AngLimit)) return AngLimit;
    if (s < -(ZW+1)'(AngLimit)) return -AngLimit;
    return s[AngW-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/rotation_matrix_to_euler_angles_unit.sv]
`default_nettype none
// ZYX Euler angles from a rotation matrix.
// Input channel: in_valid / in_stall with seven Q1.14 matrix elements.
// Output channel: out_valid / out_stall with roll, pitch, yaw (Q2.13 rad)
// and is_singular.
// Config: cfg_we / cfg_data write singular_threshold (Q1.14), reset value 1 LSB.
// Two CORDIC chains of min(CORDIC_STAGES, 24) cells each: the first finds yaw,
// sy and both roll candidates; the second finds pitch from sy.
// Throughput: one matrix per cycle while the pipeline is not stalled.
// The whole pipeline advances as one; when the output register is full
// and out_stall is high, every stage holds and in_stall rises.
// A matrix is accepted whenever the output register is empty or taken,
// so the block keeps taking requests while a result waits only if it is
// being taken in the same cycle.
// Reset clears all valid flags and sets the threshold to one LSB.
module rotation_matrix_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [rme_pkg::ThrW-1:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r00,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r10,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r11,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r12,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r20,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r21,
  input  wire logic signed [rme_pkg::ElemW-1:0] elem_r22,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [rme_pkg::AngW-1:0] roll_angle,
  output logic signed [rme_pkg::AngW-1:0] pitch_angle,
  output logic signed [rme_pkg::AngW-1:0] yaw_angle,
  output logic      is_singular
);
  import rme_pkg::*;

  localparam int NStg  = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
  localparam int Depth = 2 * NStg + 4;
  localparam int SideW = 3 * AngW + DataW + 1;
  localparam int MagW  = 34;

  logic [ThrW-1:0] thr;
  logic [Depth-1:0] vld;
  logic en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrW'(1);
      vld <= '0;
    end else begin
      if (cfg_we) thr <= cfg_data;
      if (en) vld <= {vld[Depth-2:0], in_valid};
    end
  end

  function automatic data_t ext(input logic signed [ElemW-1:0] e);
    return data_t'(e) <<< 16;
  endfunction

  // Stage 0: pre-rotation register for yaw and both roll candidates.
  vec_t [NumVec-1:0] a_in;
  logic signed [DataW-1:0] r20_s0;
  always_ff @(posedge clk) begin
    if (en) begin
      a_in[0] <= vec_init(ext(elem_r00), ext(elem_r10));
      a_in[1] <= vec_init(ext(elem_r22), ext(elem_r21));
      a_in[2] <= vec_init(ext(elem_r11), -ext(elem_r12));
      a_in[3] <= '0;
      r20_s0  <= -ext(elem_r20);
    end
  end

  vec_t [NumVec-1:0] a_out;
  logic [DataW-1:0]  r20_a;
  rme_chain #(.Stages(NStg), .Width(DataW)) u_chain_a (
    .clk, .en, .vin(a_in), .side_in(r20_s0), .vout(a_out), .side_out(r20_a)
  );

  // The yaw magnitude is never negative and stays below 2^33.
  logic signed [MagW-1:0] mag_a;
  assign mag_a = a_out[0].zero ? '0 : a_out[0].x[MagW-1:0];

  // Gain compensation: one multiply, then round and compare.
  logic signed [DataW+32-1:0] prod;
  logic [2*AngW:0] mid_ang;
  logic signed [DataW-1:0] r20_m;
  logic mid_zero;
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= (DataW+32)'(mag_a) * (DataW+32)'(InvGain);
      mid_ang  <= {angle_out(a_out[1]), angle_out(a_out[0]), 1'b0};
      r20_m    <= r20_a;
      mid_zero <= 1'b0;
    end
  end
  logic signed [AngW-1:0] roll_alt_m;
  always_ff @(posedge clk) begin
    if (en) roll_alt_m <= angle_out(a_out[2]);
  end

  data_t sy30;
  logic signed [DataW-1:0] sy14;
  logic sing;
  assign sy30 = data_t'(prod >>> 30);
  assign sy14 = (sy30 + data_t'(32768)) >>> 16;
  assign sing = sy14 < data_t'({1'b0, thr}) || mid_zero;

  vec_t [NumVec-1:0] b_in;
  logic [SideW-1:0] side_b;
  always_ff @(posedge clk) begin
    if (en) begin
      b_in[0] <= vec_init(sy30, r20_m);
      b_in[1] <= '0;
      b_in[2] <= '0;
      b_in[3] <= '0;
      side_b  <= {sing ? roll_alt_m : mid_ang[2*AngW:AngW+1],
                  sing ? AngW'(0) : mid_ang[AngW:1],
                  {AngW{1'b0}}, {DataW{1'b0}}, sing};
    end
  end

  vec_t [NumVec-1:0] b_out;
  logic [SideW-1:0]  side_o;
  rme_chain #(.Stages(NStg), .Width(SideW)) u_chain_b (
    .clk, .en, .vin(b_in), .side_in(side_b), .vout(b_out), .side_out(side_o)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= side_o[SideW-1 -: AngW];
      yaw_angle   <= side_o[SideW-AngW-1 -: AngW];
      pitch_angle <= angle_out(b_out[0]);
      is_singular <= side_o[0];
    end
  end
endmodule
`default_nettype wire

[rtl/core/rme_cell.sv]
`default_nettype none
module rme_cell #(
  parameter int Stage = 0,
  parameter int Width = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire rme_pkg::vec_t [rme_pkg::NumVec-1:0] vin,
  input  wire logic [Width-1:0] side_in,
  output rme_pkg::vec_t [rme_pkg::NumVec-1:0] vout,
  output logic      [Width-1:0] side_out
);
  import rme_pkg::*;

  localparam ang_t Step = atan_entry(Stage);

  vec_t [NumVec-1:0] nxt;

  always_comb begin
    for (int k = 0; k < NumVec; k++) begin
      nxt[k] = vin[k];
      if (vin[k].y >= 0) begin
        nxt[k].x = vin[k].x + (vin[k].y >>> Stage);
        nxt[k].y = vin[k].y - (vin[k].x >>> Stage);
        nxt[k].z = vin[k].z + Step;
      end else begin
        nxt[k].x = vin[k].x - (vin[k].y >>> Stage);
        nxt[k].y = vin[k].y + (vin[k].x >>> Stage);
        nxt[k].z = vin[k].z - Step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout     <= nxt;
      side_out <= side_in;
    end
  end
endmodule
`default_nettype wire

[rtl/core/rme_chain.sv]
`default_nettype none
module rme_chain #(
  parameter int Stages = 16,
  parameter int Width  = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire rme_pkg::vec_t [rme_pkg::NumVec-1:0] vin,
  input  wire logic [Width-1:0] side_in,
  output rme_pkg::vec_t [rme_pkg::NumVec-1:0] vout,
  output logic      [Width-1:0] side_out
);
  import rme_pkg::*;

  wire vec_t [Stages:0][NumVec-1:0] v;
  wire logic [Stages:0][Width-1:0]  s;

  assign v[0] = vin;
  assign s[0] = side_in;

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    rme_cell #(.Stage(i), .Width(Width)) u_cell (
      .clk, .en, .vin(v[i]), .side_in(s[i]), .vout(v[i+1]), .side_out(s[i+1])
    );
  end

  assign vout     = v[Stages];
  assign side_out = s[Stages];
endmodule
`default_nettype wire

[rtl/core/rme_checker.sv]
`default_nettype none
`include "rotation_matrix_to_euler_angles_unit_assert.svh"
module rme_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic is_singular,
  input wire logic signed [15:0] yaw_angle,
  input wire logic signed [15:0] roll_angle
);
  `RME_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `RME_ASSERT_ALWAYS(a_stall_only_full, clk, rst, !in_stall || (out_valid && out_stall), "needless stall")
  `RME_ASSERT_ALWAYS(a_sing_yaw, clk, rst, !(out_valid && is_singular) || yaw_angle == 16'sd0, "yaw not zero when singular")
  `RME_ASSERT_ALWAYS(a_roll_range, clk, rst, !out_valid || (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736), "roll out of range")
endmodule

bind rotation_matrix_to_euler_angles_unit rme_checker u_rme_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .is_singular, .yaw_angle, .roll_angle
);
`default_nettype wire
